// ===== rtl/bia_pkg.sv =====
package bia_pkg;

    localparam int ID_W              = 5;
    localparam int ID_LIMIT          = 32;
    localparam int POOL_SIZE_DEFAULT = 32;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] free_id;
    } req_t;

    typedef struct packed {
        logic [1:0]      status;
        logic [ID_W-1:0] granted_id;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan_step;
        logic commit_alloc;
        logic commit_full;
        logic commit_free;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/bia_ctrl.sv =====
module bia_ctrl
    import bia_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  logic req_kind,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign req_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = (req_kind == KIND_FREE) ? ST_FREE : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.hit || sts.last)
                begin
                    // finish only once the result slot can take it
                    if (sts.out_free)
                    begin
                        cmd.commit_alloc = sts.hit;
                        cmd.commit_full  = !sts.hit;
                        state_next       = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_FREE:
            begin
                if (sts.out_free)
                begin
                    cmd.commit_free = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/bia_dp.sv =====
module bia_dp
    import bia_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output rsp_t rsp,
    output logic rsp_valid,
    input  logic rsp_ready
);

    localparam int EFF_POOL = (POOL_SIZE > ID_LIMIT) ? ID_LIMIT : POOL_SIZE;
    localparam int IDX_W    = $clog2(EFF_POOL);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(EFF_POOL - 1);

    logic [EFF_POOL-1:0] used_reg,      used_next;
    logic [IDX_W-1:0]    ptr_reg,       ptr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [IDX_W-1:0]    idx_reg,       idx_next;
    logic [IDX_W-1:0]    cnt_reg,       cnt_next;
    logic [ID_W-1:0]     id_reg,        id_next;
    rsp_t                rsp_reg,       rsp_next;

    logic [IDX_W-1:0] idx_inc;
    logic [IDX_W-1:0] free_idx;
    logic             free_ok;

    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign free_idx = id_reg[IDX_W-1:0];
    assign free_ok  = ({1'b0, id_reg} < (ID_W+1)'(EFF_POOL)) && used_reg[free_idx];

    assign sts.hit      = !used_reg[idx_reg];
    assign sts.last     = (cnt_reg == LAST_IDX);
    assign sts.out_free = !rsp_valid_reg || rsp_ready;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        used_next      = used_reg;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        if (cmd.load)
        begin
            idx_next = ptr_reg;
            cnt_next = '0;
            id_next  = req.free_id;
        end

        if (cmd.scan_step)
        begin
            idx_next = idx_inc;
            cnt_next = cnt_reg + 1'b1;
        end

        if (cmd.commit_alloc)
        begin
            used_next[idx_reg]  = 1'b1;
            ptr_next            = idx_inc;
            rsp_next.status     = STATUS_OK;
            rsp_next.granted_id = ID_W'(idx_reg);
            rsp_valid_next      = 1'b1;
        end

        if (cmd.commit_full)
        begin
            rsp_next.status     = STATUS_FULL;
            rsp_next.granted_id = '0;
            rsp_valid_next      = 1'b1;
        end

        if (cmd.commit_free)
        begin
            rsp_next.granted_id = '0;
            rsp_valid_next      = 1'b1;
            if (free_ok)
            begin
                used_next[free_idx] = 1'b0;
                if (free_idx < ptr_reg)
                begin
                    ptr_next = free_idx;
                end
                rsp_next.status = STATUS_OK;
            end
            else
            begin
                rsp_next.status = STATUS_NOT_ALLOC;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            ptr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            ptr_reg       <= ptr_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        cnt_reg <= cnt_next;
        id_reg  <= id_next;
        rsp_reg <= rsp_next;
    end

endmodule

// ===== rtl/bitmap_id_allocator.sv =====
// Next-fit identifier allocator over a pool of min(POOL_SIZE, 32) identifiers.
// Request channel (req_valid/req_ready, req): kind selects allocate or free;
// free_id names the identifier to release. Response channel (rsp_valid/
// rsp_ready, rsp): status and granted_id, exactly one response per request.
// Allocate tests one bitmap bit per cycle starting at the next-fit pointer:
// the scan stops at the first clear bit, or reports a full pool once every
// bit of the pool has been tested; the response is then registered.
// Free needs no scan: it checks its bit in ST_FREE and clears it if set.
// The bit-serial scan limits the allocate rate.
// A new request is taken once the previous one is finished, even while its
// response still sits in the output register. If the receiver stalls, a
// finished request holds in the controller until the output register frees.
// Reset (rst_n, async, active low) clears the bitmap, the pointer and the
// response valid; the controller leaves reset idle, ready for a request.
module bitmap_id_allocator
    import bia_pkg::*;
#(
    parameter int POOL_SIZE = POOL_SIZE_DEFAULT
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    bia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_kind  (req.kind),
        .sts       (sts),
        .cmd       (cmd)
    );

    bia_dp #(
        .POOL_SIZE (POOL_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

endmodule
